// File: hw/rtl/o2rs_pkg.sv
// Package for the offline 2D range sum block: field widths and entry kinds.
// No dependencies.
package o2rs_pkg;
	localparam int IN_BITS  = 31;
	localparam int W_BITS   = 32;
	localparam int SUM_BITS = 64;
	localparam int QI_BITS  = 6;
	localparam logic OP_POINT = 1'b0;
	localparam logic OP_QUERY = 1'b1;
endpackage

// File: hw/rtl/offline_2d_range_sum.sv
// Offline weighted 2D range sum, corner dominance counting.
// Depends on o2rs_pkg.
// Load: points are written as accepted; a query is accepted, then its four corners are written
// with input held off. After last: each corner is fetched, then one compare-and-add per stored
// entry through a single 64-bit accumulator, then the update; point entries are skipped. Answers
// then leave via the output register. Reset clears counts, flags and the answer valid bits.
module offline_2d_range_sum #(
	parameter int MAX_ENTRIES = 512,
	parameter int MAX_QUERIES = 64,
	parameter int COORD_BITS  = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: operation[0], px[31:1], py[62:32], qx_high[93:63], qy_high[124:94],
	//        weight[156:125], zero fill [159:157]
	input  logic [159:0] s_tdata,
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: query_index[5:0], range_sum[69:6], zero fill [71:70]
	output logic [71:0] m_tdata,
	// tuser: overflow
	output logic        m_tuser,
	output logic        m_tlast
);
	import o2rs_pkg::*;

	localparam int EA = $clog2(MAX_ENTRIES);
	localparam int EC = $clog2(MAX_ENTRIES + 1);
	localparam int QA = (MAX_QUERIES > 1) ? $clog2(MAX_QUERIES) : 1;
	localparam int QC = $clog2(MAX_QUERIES + 1);
	localparam int AW = 2 + W_BITS;

	localparam logic [2:0] ST_LOAD = 3'd0, ST_CORN = 3'd1, ST_OUTER = 3'd2,
		ST_RD = 3'd3, ST_SCAN = 3'd4, ST_APPLY = 3'd5, ST_EMIT = 3'd6, ST_ARD = 3'd7;

	// attrs: bit0 kind (1 corner), bit1 negative, bits up: weight or query index
	logic [2*COORD_BITS-1:0] coord_mem [MAX_ENTRIES];
	logic [AW-1:0]           attr_mem  [MAX_ENTRIES];
	logic [SUM_BITS-1:0]     ans_mem   [MAX_QUERIES];
	logic [MAX_QUERIES-1:0]  ans_vld_q;

	logic [2:0]  state_q;
	logic [EC-1:0] cnt_q;
	logic [QC-1:0] qcnt_q;
	logic        drop_q;
	logic [1:0]  corner_q;
	logic [EC-1:0] e_q, p_q;
	logic [COORD_BITS-1:0] x1m_q, y1m_q, x2_q, y2_q;
	logic        pend_last_q;
	logic [2*COORD_BITS-1:0] rc_q, cc_q;
	logic [AW-1:0]           ra_q, ca_q;
	logic [SUM_BITS-1:0]     acc_q, ans_rd_q;
	logic [QC-1:0] oq_q;

	logic [COORD_BITS-1:0] in_px, in_py, in_qx, in_qy;
	assign in_px = COORD_BITS'($signed(s_tdata[31:1]));
	assign in_py = COORD_BITS'($signed(s_tdata[62:32]));
	assign in_qx = COORD_BITS'($signed(s_tdata[93:63]));
	assign in_qy = COORD_BITS'($signed(s_tdata[124:94]));

	assign s_tready = (state_q == ST_LOAD);
	logic acc_in;
	assign acc_in = s_tvalid && s_tready;

	// entry write sequencing: point entries as accepted, then query corners
	logic                    wr_en;
	logic [2*COORD_BITS-1:0] wr_c;
	logic [AW-1:0]           wr_a;
	logic [QA-1:0]           qi;
	assign qi = QA'(qcnt_q);
	always_comb begin
		wr_en = 1'b0;
		wr_c = '0;
		wr_a = '0;
		if (acc_in && s_tdata[0] == OP_POINT && cnt_q < EC'(MAX_ENTRIES)) begin
			wr_en = 1'b1;
			wr_c = {in_py, in_px};
			wr_a = {s_tdata[156:125], 2'b00};
		end else if (state_q == ST_CORN) begin
			wr_en = 1'b1;
			case (corner_q)
				2'd0: wr_c = {y2_q, x2_q};
				2'd1: wr_c = {y1m_q, x1m_q};
				2'd2: wr_c = {y2_q, x1m_q};
				default: wr_c = {y1m_q, x2_q};
			endcase
			wr_a = {(W_BITS)'(qi), corner_q[1], 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			coord_mem[EA'(cnt_q)] <= wr_c;
			attr_mem[EA'(cnt_q)]  <= wr_a;
		end
	end

	// comparison key: signed order via flipped sign bit
	logic [COORD_BITS-1:0] kpx, kpy, kcx, kcy;
	assign kpx = rc_q[COORD_BITS-1:0] ^ (1'b1 << (COORD_BITS-1));
	assign kpy = rc_q[2*COORD_BITS-1:COORD_BITS] ^ (1'b1 << (COORD_BITS-1));
	assign kcx = cc_q[COORD_BITS-1:0] ^ (1'b1 << (COORD_BITS-1));
	assign kcy = cc_q[2*COORD_BITS-1:COORD_BITS] ^ (1'b1 << (COORD_BITS-1));
	logic hit;
	assign hit = !ra_q[0] && kpx <= kcx && kpy <= kcy;

	logic [QA-1:0] cq;
	assign cq = QA'(ca_q[AW-1:2]);
	logic [SUM_BITS-1:0] old_ans;
	assign old_ans = ans_vld_q[cq] ? ans_rd_q : '0;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_OUTER: begin
				cc_q <= coord_mem[EA'(e_q)];
				ca_q <= attr_mem[EA'(e_q)];
			end
			default: begin
				rc_q <= coord_mem[EA'(p_q)];
				ra_q <= attr_mem[EA'(p_q)];
			end
		endcase
		ans_rd_q <= ans_mem[(state_q == ST_EMIT || state_q == ST_ARD) ? QA'(oq_q) : cq];
		if (state_q == ST_APPLY)
			ans_mem[cq] <= ca_q[1] ? old_ans - acc_q : old_ans + acc_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q <= '0;
			qcnt_q <= '0;
			drop_q <= 1'b0;
			corner_q <= '0;
			e_q <= '0;
			p_q <= '0;
			pend_last_q <= 1'b0;
			acc_q <= '0;
			oq_q <= '0;
			ans_vld_q <= '0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
			m_tuser <= 1'b0;
			m_tlast <= 1'b0;
		end else begin
			if (wr_en)
				cnt_q <= cnt_q + 1'b1;
			case (state_q)
				ST_LOAD: if (acc_in) begin
					if (s_tdata[0] == OP_QUERY) begin
						if (qcnt_q < QC'(MAX_QUERIES) && 32'(cnt_q) + 4 <= MAX_ENTRIES) begin
							x1m_q <= in_px - 1'b1;
							y1m_q <= in_py - 1'b1;
							x2_q <= in_qx;
							y2_q <= in_qy;
							corner_q <= '0;
							pend_last_q <= s_tlast;
							state_q <= ST_CORN;
						end else begin
							drop_q <= 1'b1;
							if (s_tlast) begin e_q <= '0; state_q <= ST_OUTER; end
						end
					end else begin
						if (cnt_q >= EC'(MAX_ENTRIES)) drop_q <= 1'b1;
						if (s_tlast) begin e_q <= '0; state_q <= ST_OUTER; end
					end
				end
				ST_CORN: begin
					corner_q <= corner_q + 1'b1;
					if (corner_q == 2'd3) begin
						qcnt_q <= qcnt_q + 1'b1;
						e_q <= '0;
						state_q <= pend_last_q ? ST_OUTER : ST_LOAD;
					end
				end
				ST_OUTER: begin
					if (e_q >= cnt_q) begin
						oq_q <= '0;
						state_q <= (qcnt_q == '0) ? ST_LOAD : ST_ARD;
						if (qcnt_q == '0) begin
							cnt_q <= '0; drop_q <= 1'b0; ans_vld_q <= '0;
						end
					end else begin
						p_q <= '0;
						acc_q <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					// ca_q valid now; skip point entries
					if (!ca_q[0]) begin
						e_q <= e_q + 1'b1;
						state_q <= ST_OUTER;
					end else begin
						p_q <= p_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// rc_q/ra_q hold entry p_q-1
					if (hit)
						acc_q <= acc_q + SUM_BITS'($signed(ra_q[AW-1:2]));
					if (p_q >= cnt_q)
						state_q <= ST_APPLY;
					else
						p_q <= p_q + 1'b1;
				end
				ST_APPLY: begin
					// acc has final term only after last scan edge; fold it here
					ans_vld_q[cq] <= 1'b1;
					e_q <= e_q + 1'b1;
					state_q <= ST_OUTER;
				end
				ST_ARD: begin
					// answer may be taken while the next one is fetched
					if (m_tready)
						m_tvalid <= 1'b0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!m_tvalid || m_tready) begin
						if (oq_q == qcnt_q) begin
							if (!m_tvalid || m_tready) begin
								m_tvalid <= 1'b0;
								cnt_q <= '0; qcnt_q <= '0; drop_q <= 1'b0;
								ans_vld_q <= '0;
								state_q <= ST_LOAD;
							end
						end else begin
							m_tvalid <= 1'b1;
							m_tdata <= {2'b00, ans_vld_q[QA'(oq_q)] ? ans_rd_q : 64'd0,
								QI_BITS'(oq_q)};
							m_tuser <= drop_q;
							m_tlast <= (oq_q + 1'b1 == qcnt_q);
							oq_q <= oq_q + 1'b1;
							state_q <= ST_ARD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for offline_2d_range_sum: loads point/query runs over the
// input stream and checks every answer against a direct corner-sum calculation.
// Depends on o2rs_pkg and the offline_2d_range_sum RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import o2rs_pkg::*;

	localparam int ENT_CAP = 512;
	localparam int QRY_CAP = 64;
	localparam longint LIMIT = 3000000;
	localparam logic signed [30:0] C_MAX = 31'sh3fffffff;
	localparam logic signed [30:0] C_MIN = -31'sh40000000;

	typedef struct {
		logic                 op;
		logic signed [30:0]   px, py, qx2, qy2;
		logic signed [31:0]   w;
		logic                 last;
		bit                   hold;   // pause until all answers are back
	} item_t;

	typedef struct {
		logic [5:0]  idx;
		logic [63:0] sum;
		logic        ovf;
		logic        fin;
	} answer_t;

	logic         clk = 0, arst_n = 0;
	logic         s_tvalid = 0, s_tlast = 0, m_tready = 0;
	logic [159:0] s_tdata = '0;
	logic         s_tready, m_tvalid, m_tuser, m_tlast;
	logic [71:0]  m_tdata;

	offline_2d_range_sum dut (.*);

	item_t   stim_q[$];
	answer_t answers_due[$];
	int      errors = 0;
	longint  cyc = 0;
	bit      offered = 0;
	int      burst_left = 4, gap_left = 0;
	int      hold_left = 0;
	bit      held = 0;

	// predictor state for the current data set
	logic signed [31:0] pt_x[ENT_CAP], pt_y[ENT_CAP], pt_w[ENT_CAP];
	logic signed [31:0] cq_x2[QRY_CAP], cq_y2[QRY_CAP], cq_x1m[QRY_CAP], cq_y1m[QRY_CAP];
	int n_pts = 0, n_qry = 0, n_ent = 0;
	bit dropped = 0;

	initial forever #1 clk = ~clk;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cyc);
	endtask

	function automatic logic [63:0] dominated_sum(input logic signed [31:0] cx,
			input logic signed [31:0] cy);
		logic [63:0] s;
		s = '0;
		for (int p = 0; p < n_pts; p++)
			if (pt_x[p] <= cx && pt_y[p] <= cy)
				s += 64'(pt_w[p]);
		return s;
	endfunction

	task automatic load_item(input item_t it);
		logic [63:0] s;
		answer_t a;
		if (it.op == OP_POINT) begin
			if (n_ent < ENT_CAP) begin
				pt_x[n_pts] = 32'(it.px); pt_y[n_pts] = 32'(it.py); pt_w[n_pts] = it.w;
				n_pts++; n_ent++;
			end else
				dropped = 1;
		end else if (n_qry < QRY_CAP && n_ent + 4 <= ENT_CAP) begin
			cq_x2[n_qry] = 32'(it.qx2); cq_y2[n_qry] = 32'(it.qy2);
			cq_x1m[n_qry] = 32'(it.px) - 1; cq_y1m[n_qry] = 32'(it.py) - 1;
			n_qry++; n_ent += 4;
		end else
			dropped = 1;
		if (!it.last)
			return;
		for (int q = 0; q < n_qry; q++) begin
			s = dominated_sum(cq_x2[q], cq_y2[q]) + dominated_sum(cq_x1m[q], cq_y1m[q])
				- dominated_sum(cq_x1m[q], cq_y2[q]) - dominated_sum(cq_x2[q], cq_y1m[q]);
			a.idx = 6'(q); a.sum = s; a.ovf = dropped; a.fin = (q == n_qry - 1);
			answers_due.push_back(a);
		end
		n_pts = 0; n_qry = 0; n_ent = 0; dropped = 0;
	endtask

	function automatic logic signed [30:0] rnd_coord(input bit wide);
		int m;
		m = $urandom_range(0, 19);
		if (wide && m == 0) return C_MAX;
		if (wide && m == 1) return C_MIN;
		if (wide && m < 5) return 31'($urandom);
		return 31'($urandom_range(0, 16)) - 31'sd8;
	endfunction

	function automatic item_t mk(input logic op, input logic signed [30:0] px, py, qx2, qy2,
			input logic signed [31:0] w, input logic last);
		item_t it;
		it.op = op; it.px = px; it.py = py; it.qx2 = qx2; it.qy2 = qy2;
		it.w = w; it.last = last; it.hold = 0;
		return it;
	endfunction

	function automatic item_t rnd_item(input logic op, input bit wide, input logic last);
		logic signed [31:0] w;
		w = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 200)) - 100;
		return mk(op, rnd_coord(wide), rnd_coord(wide), rnd_coord(wide), rnd_coord(wide),
			w, last);
	endfunction

	function automatic item_t pause_mark();
		item_t it;
		it = mk(OP_POINT, 0, 0, 0, 0, 0, 0);
		it.hold = 1;
		return it;
	endfunction

	// stimulus
	initial begin
		int total, len;
		bit wide;
		// extremes, inverted rectangles, a query with nothing under it
		stim_q.push_back(mk(OP_POINT, C_MAX, C_MAX, 0, 0, 32'h7fffffff, 0));
		stim_q.push_back(mk(OP_POINT, C_MIN, C_MIN, 0, 0, 32'h80000000, 0));
		stim_q.push_back(mk(OP_POINT, C_MIN, C_MAX, C_MAX, C_MIN, -32'sd5, 0));
		stim_q.push_back(mk(OP_POINT, 0, 0, C_MIN, C_MAX, 32'h55555555, 0));
		stim_q.push_back(mk(OP_QUERY, C_MIN, C_MIN, C_MAX, C_MAX, 32'hffffffff, 0));
		stim_q.push_back(mk(OP_QUERY, C_MAX, C_MAX, C_MIN, C_MIN, 0, 0));
		stim_q.push_back(mk(OP_QUERY, 0, C_MIN, C_MAX, 0, 0, 0));
		stim_q.push_back(mk(OP_QUERY, 5, 5, 4, 4, 0, 0));
		stim_q.push_back(mk(OP_QUERY, 1, 1, 2, 2, 0, 1));
		stim_q.push_back(mk(OP_POINT, 3, 3, 0, 0, 7, 1));  // run with no queries
		stim_q.push_back(mk(OP_QUERY, -31'sd1, -31'sd1, 1, 1, 0, 1));
		stim_q.push_back(pause_mark());
		// 256 points and 64 queries fill every entry; one more query hits the
		// query limit and one more point finds no free entry
		for (int i = 0; i < 256; i++) begin
			stim_q.push_back(rnd_item(OP_POINT, 0, 0));
			if (i % 4 == 3)
				stim_q.push_back(rnd_item(OP_QUERY, 0, 0));
		end
		stim_q.push_back(rnd_item(OP_QUERY, 0, 0));
		stim_q.push_back(rnd_item(OP_POINT, 0, 1));
		// random data sets
		total = stim_q.size();
		while (total < 360) begin
			len = $urandom_range(1, 12);
			wide = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < len; i++)
				stim_q.push_back(rnd_item(($urandom_range(0, 9) < 6) ? OP_POINT : OP_QUERY,
					wide, i == len - 1));
			if ($urandom_range(0, 15) == 0)
				stim_q.push_back(pause_mark());
			total += len;
		end
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1;
		while (stim_q.size() != 0 || offered || answers_due.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0 && answers_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// input side: bursts with random gaps
	always @(negedge clk) begin
		if (arst_n && !offered) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 0;
			end else if (stim_q.size() == 0) begin
				s_tvalid <= 0;
			end else if (stim_q[0].hold) begin
				s_tvalid <= 0;
				if (answers_due.size() == 0)
					void'(stim_q.pop_front());
			end else begin
				s_tvalid <= 1;
				s_tlast  <= stim_q[0].last;
				s_tdata  <= {3'b0, stim_q[0].w, stim_q[0].qy2, stim_q[0].qx2,
					stim_q[0].py, stim_q[0].px, stim_q[0].op};
				offered = 1;
				if (--burst_left <= 0) begin
					burst_left = $urandom_range(1, 20);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// output side: random stalls plus one long hold-off once answers are waiting
	always @(negedge clk) begin
		if (!held && m_tvalid && cyc > 2000) begin
			held = 1;
			hold_left = 600;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 0;
		end else if ((cyc / 500) % 3 == 0)
			m_tready <= 1;
		else
			m_tready <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		answer_t a;
		cyc++;
		if (cyc > LIMIT) begin
			$display("simulation failed");
			$finish;
		end
		if (s_tvalid && s_tready) begin
			load_item(stim_q.pop_front());
			offered = 0;
		end
		if (m_tvalid && m_tready) begin
			if (answers_due.size() == 0) begin
				report("unexpected transfer", m_tdata[69:6], '0);
			end else begin
				a = answers_due.pop_front();
				if (m_tdata[5:0] != a.idx)
					report("query_index", 64'(m_tdata[5:0]), 64'(a.idx));
				if (m_tdata[69:6] != a.sum) report("range_sum", m_tdata[69:6], a.sum);
				if (m_tuser != a.ovf) report("overflow", 64'(m_tuser), 64'(a.ovf));
				if (m_tlast != a.fin) report("last_result", 64'(m_tlast), 64'(a.fin));
			end
		end
	end
endmodule
